// File: rtl/core/mcct_pkg.sv
// ----------------------------------------------------------------------------
// mcct_pkg
// Shared types and constants for the multi-channel compare timer: command
// codes, result vector codes and the transfer payloads of both channels.
// ----------------------------------------------------------------------------
package mcct_pkg;

  localparam int NumChannelsDefault = 7;
  localparam int CountWidthDefault  = 16;

  // Divider range; the register is seven bits wide.
  localparam int DivWidth = 7;
  localparam logic [DivWidth-1:0] DIV_RESET = 7'd1;
  localparam logic [DivWidth-1:0] DIV_MIN   = 7'd1;
  localparam logic [DivWidth-1:0] DIV_MAX   = 7'd64;
  localparam int DivCountWidth = 6;

  // Configuration register indexes.
  localparam logic REG_CLOCK_DIVIDE = 1'b0;

  typedef enum logic [1:0] {
    CMD_TICK       = 2'd0,
    CMD_SET_PERIOD = 2'd1,
    CMD_ENABLE     = 2'd2,
    CMD_SERVICE    = 2'd3
  } cmd_t;

  // Channel code that names the counter overflow source.
  localparam logic [2:0] CH_OVERFLOW = 3'd7;

  localparam logic [3:0] VEC_NONE     = 4'd0;
  localparam logic [3:0] VEC_OVERFLOW = 4'd8;

  typedef struct packed {
    cmd_t        cmd;
    logic [2:0]  channel;
    logic [15:0] value;
  } item_t;

  typedef struct packed {
    logic [3:0]  vector;
    logic        irq;
    logic [15:0] count;
  } result_t;

  // Counter event of one step, from the prescaler to the compare channels.
  typedef struct packed {
    logic advance;
    logic wrap;
  } count_evt_t;

endpackage

// File: rtl/core/mcct_prescaler.sv
// ----------------------------------------------------------------------------
// mcct_prescaler
// Clock divider and free-running counter. Shows the counter value after the
// current step and whether it advanced or wrapped.
// ----------------------------------------------------------------------------
module mcct_prescaler #(
  parameter int COUNT_WIDTH = mcct_pkg::CountWidthDefault
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              tick,
  input  logic [mcct_pkg::DivWidth-1:0]     clock_divide,
  output logic [COUNT_WIDTH-1:0]            count_next,
  output mcct_pkg::count_evt_t              evt
);
  import mcct_pkg::*;

  logic [COUNT_WIDTH-1:0]   counter;
  logic [DivCountWidth-1:0] divide_count;
  logic [DivCountWidth-1:0] divide_count_next;
  logic [DivWidth-1:0]      div_eff;
  logic [DivWidth-1:0]      div_inc;

  always_comb begin
    // Out-of-range divider settings are clamped to the nearest legal value.
    if (clock_divide < DIV_MIN) begin
      div_eff = DIV_MIN;
    end else if (clock_divide > DIV_MAX) begin
      div_eff = DIV_MAX;
    end else begin
      div_eff = clock_divide;
    end
    div_inc = {1'b0, divide_count} + DivWidth'(1);

    divide_count_next = divide_count;
    count_next        = counter;
    evt               = '0;
    if (tick) begin
      if (div_inc < div_eff) begin
        divide_count_next = div_inc[DivCountWidth-1:0];
      end else begin
        divide_count_next = '0;
        count_next        = counter + COUNT_WIDTH'(1);
        evt.advance       = 1'b1;
        evt.wrap          = &counter;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter      <= '0;
      divide_count <= '0;
    end else begin
      counter      <= count_next;
      divide_count <= divide_count_next;
    end
  end

endmodule

// File: rtl/core/mcct_channels.sv
// ----------------------------------------------------------------------------
// mcct_channels
// Compare channels, pending and enable flags, and the service priority
// encoder. Produces the vector and interrupt state after the current step.
// ----------------------------------------------------------------------------
module mcct_channels #(
  parameter int NUM_CHANNELS = mcct_pkg::NumChannelsDefault,
  parameter int COUNT_WIDTH  = mcct_pkg::CountWidthDefault
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  mcct_pkg::item_t        item,
  input  logic [COUNT_WIDTH-1:0] count_next,
  input  mcct_pkg::count_evt_t   evt,
  output logic [3:0]             vector,
  output logic                   irq
);
  import mcct_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CMP_RESET = COUNT_WIDTH'(32'hffff);

  logic [COUNT_WIDTH-1:0]  compare_value [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0]  compare_step  [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0]  compare_value_next [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0]  compare_step_next  [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] pending, pending_next;
  logic [NUM_CHANNELS-1:0] enable, enable_next;
  logic                    ovf_pending, ovf_pending_next;
  logic                    ovf_enable, ovf_enable_next;
  logic [NUM_CHANNELS-1:0] active;
  logic [COUNT_WIDTH-1:0]  period_step;
  logic                    found;

  always_comb begin
    compare_value_next = compare_value;
    compare_step_next  = compare_step;
    pending_next       = pending;
    enable_next        = enable;
    ovf_pending_next   = ovf_pending;
    ovf_enable_next    = ovf_enable;
    vector             = VEC_NONE;
    active             = pending & enable;
    found              = 1'b0;
    // A period of zero wraps to all ones at the counter width.
    period_step        = COUNT_WIDTH'(item.value) - COUNT_WIDTH'(1);

    if (fire) begin
      unique case (item.cmd)
        CMD_TICK: begin
          if (evt.advance) begin
            if (evt.wrap) begin
              ovf_pending_next = 1'b1;
            end
            for (int i = 0; i < NUM_CHANNELS; i++) begin
              if (compare_value[i] == count_next) begin
                pending_next[i] = 1'b1;
              end
            end
          end
        end
        CMD_SET_PERIOD: begin
          for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (item.channel == 3'(i)) begin
              compare_step_next[i]  = period_step;
              compare_value_next[i] = period_step;
              pending_next[i]       = 1'b0;
              enable_next[i]        = 1'b0;
            end
          end
        end
        CMD_ENABLE: begin
          for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (item.channel == 3'(i)) begin
              pending_next[i] = 1'b0;
              enable_next[i]  = 1'b1;
            end
          end
          if (item.channel == CH_OVERFLOW) begin
            ovf_pending_next = 1'b0;
            ovf_enable_next  = 1'b1;
          end
        end
        CMD_SERVICE: begin
          // Lowest channel number wins; overflow only when no channel is due.
          for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (active[i] && !found) begin
              found                 = 1'b1;
              compare_value_next[i] = compare_value[i] + compare_step[i];
              pending_next[i]       = 1'b0;
              vector                = 4'(i + 1);
            end
          end
          if (!found && ovf_pending && ovf_enable) begin
            ovf_pending_next = 1'b0;
            vector           = VEC_OVERFLOW;
          end
        end
        default: begin
        end
      endcase
    end

    irq = (|(pending_next & enable_next)) | (ovf_pending_next & ovf_enable_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        compare_value[i] <= CMP_RESET;
        compare_step[i]  <= CMP_RESET;
      end
      pending     <= '0;
      enable      <= '0;
      ovf_pending <= 1'b0;
      ovf_enable  <= 1'b0;
    end else begin
      compare_value <= compare_value_next;
      compare_step  <= compare_step_next;
      pending       <= pending_next;
      enable        <= enable_next;
      ovf_pending   <= ovf_pending_next;
      ovf_enable    <= ovf_enable_next;
    end
  end

endmodule

// File: rtl/core/multi_channel_compare_timer.sv
// ----------------------------------------------------------------------------
// multi_channel_compare_timer
// Free-running counter with compare channels, an overflow source and a
// serviced priority vector, driven by a stream of commands.
//
//   channel   signals                               direction
//   item      item_valid, item_stall, item          command transfer in
//   result    result_valid, result_stall, result    one result per command out
//   config    psel, penable, pwrite, paddr, pwdata   APB register access
//
// Each command passes through the input register and then the result
// register; one command per cycle is sustained while results are not stalled.
// All state updates for a command happen in the single cycle it leaves the
// input register. Reset clears the counter, the flags and the divider count
// and loads the compare values and steps with all ones. A stalled result
// holds the command in the input register, and item_stall rises only when
// both registers are full.
// ----------------------------------------------------------------------------
module multi_channel_compare_timer #(
  parameter int NUM_CHANNELS = mcct_pkg::NumChannelsDefault,
  parameter int COUNT_WIDTH  = mcct_pkg::CountWidthDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  mcct_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output mcct_pkg::result_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import mcct_pkg::*;

  logic                   s1_valid;
  item_t                  s1_item;
  logic                   fire;
  logic                   accept;
  logic [DivWidth-1:0]    clock_divide;
  logic [COUNT_WIDTH-1:0] count_next;
  count_evt_t             evt;
  logic [3:0]             vector;
  logic                   irq;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CLOCK_DIVIDE) ? 32'(clock_divide) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_divide <= DIV_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CLOCK_DIVIDE) begin
      clock_divide <= pwdata[DivWidth-1:0];
    end
  end

  // The command in the input register executes when the result register can
  // take its result.
  assign fire       = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !fire;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item;
    end
  end

  mcct_prescaler #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_prescaler (
    .clk         (clk),
    .rst         (rst),
    .tick        (fire && s1_item.cmd == CMD_TICK),
    .clock_divide(clock_divide),
    .count_next  (count_next),
    .evt         (evt)
  );

  mcct_channels #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_channels (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (s1_item),
    .count_next(count_next),
    .evt       (evt),
    .vector    (vector),
    .irq       (irq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.vector <= vector;
      result.irq    <= irq;
      result.count  <= 16'(count_next);
    end
  end

endmodule

// File: bench/mcct_checker.sv
// ----------------------------------------------------------------------------
// mcct_checker
// Watches the command, result and register ports of the compare timer. It
// keeps its own model of the counter, the divider, the compare channels and
// the flags, predicts one result per accepted command, and compares each
// accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcct_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  mcct_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_stall,
  input  mcct_pkg::result_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output int                fail_count,
  output int                in_flight,
  output int                checked,
  output int                wrap_count,
  output logic [8:0]        vectors_seen
);
  import mcct_pkg::*;

  localparam int NCh = NumChannelsDefault;
  localparam logic [2:0] DivideAddr = {REG_CLOCK_DIVIDE, 2'b00};

  logic [15:0]         count_q;
  logic [DivWidth-1:0] divide_q;
  logic [6:0]          phase_q;
  logic [15:0]         cmp_value [NCh];
  logic [15:0]         cmp_step [NCh];
  logic [7:0]          pend_q;
  logic [7:0]          enab_q;
  result_t             predicted_results [$];
  int                  errors;
  int                  results_done;
  int                  wraps;
  logic [8:0]          vec_hits;

  assign fail_count   = errors;
  assign checked      = results_done;
  assign wrap_count   = wraps;
  assign vectors_seen = vec_hits;

  initial begin
    errors       = 0;
    results_done = 0;
    wraps        = 0;
    vec_hits     = '0;
    in_flight    = 0;
  end

  task automatic report_error(input string msg);
    // Keep the log short when the block is badly broken; every error counts.
    if (errors < 40) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
    errors++;
  endtask

  task automatic clear_timer();
    count_q  = '0;
    divide_q = DIV_RESET;
    phase_q  = '0;
    for (int i = 0; i < NCh; i++) begin
      cmp_value[i] = 16'hffff;
      cmp_step[i]  = 16'hffff;
    end
    pend_q = '0;
    enab_q = '0;
  endtask

  task automatic advance_counter();
    logic [6:0] limit;
    limit = divide_q;
    if (limit < DIV_MIN) limit = DIV_MIN;
    if (limit > DIV_MAX) limit = DIV_MAX;
    phase_q = phase_q + 7'd1;
    if (phase_q < limit) return;
    phase_q = '0;
    if (count_q == 16'hffff) begin
      pend_q[CH_OVERFLOW] = 1'b1;
      wraps++;
    end
    count_q = count_q + 16'd1;
    // Matches set flags whether or not the channel is enabled.
    for (int i = 0; i < NCh; i++) begin
      if (cmp_value[i] == count_q) pend_q[i] = 1'b1;
    end
  endtask

  task automatic serve_highest(output logic [3:0] vec);
    logic [7:0] active;
    bit         found;
    active = pend_q & enab_q;
    vec    = VEC_NONE;
    found  = 1'b0;
    for (int i = 0; i < NCh; i++) begin
      if (!found && active[i]) begin
        cmp_value[i] = cmp_value[i] + cmp_step[i];
        pend_q[i]    = 1'b0;
        vec          = 4'(i + 1);
        found        = 1'b1;
      end
    end
    if (!found && active[CH_OVERFLOW]) begin
      pend_q[CH_OVERFLOW] = 1'b0;
      vec                 = VEC_OVERFLOW;
    end
  endtask

  task automatic timer_step(input item_t it, output result_t r);
    logic [3:0] vec;
    vec = VEC_NONE;
    case (it.cmd)
      CMD_TICK: advance_counter();
      CMD_SET_PERIOD: begin
        // The overflow source has no period, so only real channels load.
        if (int'(it.channel) < NCh) begin
          cmp_step[it.channel]  = it.value - 16'd1;
          cmp_value[it.channel] = it.value - 16'd1;
          pend_q[it.channel]    = 1'b0;
          enab_q[it.channel]    = 1'b0;
        end
      end
      CMD_ENABLE: begin
        if (int'(it.channel) < NCh || it.channel == CH_OVERFLOW) begin
          pend_q[it.channel] = 1'b0;
          enab_q[it.channel] = 1'b1;
        end
      end
      CMD_SERVICE: serve_highest(vec);
      default: ;
    endcase
    r.vector = vec;
    r.irq    = |(pend_q & enab_q);
    r.count  = count_q;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_timer();
      predicted_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == DivideAddr) begin
        divide_q = pwdata[DivWidth-1:0];
      end
      if (item_valid && !item_stall) begin
        timer_step(item, want);
        predicted_results.push_back(want);
      end
      if (result_valid && !result_stall) begin
        if (predicted_results.size() == 0) begin
          report_error($sformatf("unexpected result: vector %0d irq %0b count %h",
                                 result.vector, result.irq, result.count));
        end else begin
          want = predicted_results.pop_front();
          results_done++;
          if (result.vector <= VEC_OVERFLOW) vec_hits[result.vector] = 1'b1;
          if (result.vector !== want.vector) begin
            report_error($sformatf("vector: got %0d, expected %0d (result %0d)",
                                   result.vector, want.vector, results_done));
          end
          if (result.irq !== want.irq) begin
            report_error($sformatf("irq: got %b, expected %b (result %0d)",
                                   result.irq, want.irq, results_done));
          end
          if (result.count !== want.count) begin
            report_error($sformatf("count: got %h, expected %h (result %0d)",
                                   result.count, want.count, results_done));
          end
        end
      end
    end
    in_flight <= predicted_results.size();
  end

endmodule

// File: bench/tb_multi_channel_compare_timer.sv
// ----------------------------------------------------------------------------
// tb_multi_channel_compare_timer
// Drives the compare timer with a directed command sequence, then random
// command streams under several divider settings, and finally a short run
// that is mostly ticks. Outside the calm phase both channels idle and stall
// at random; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multi_channel_compare_timer;
  import mcct_pkg::*;

  localparam int StallPct    = 13;
  localparam int HoldCycles  = 80;
  localparam int WatchLimit  = 2000;
  localparam int PhaseItems  = 130;
  localparam int TailItems   = 14;
  localparam logic [2:0] DivideAddr = {REG_CLOCK_DIVIDE, 2'b00};

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  item_t       item;
  logic        result_valid;
  logic        result_stall;
  result_t     result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        calm;
  int          settings_done;

  int          fail_count;
  int          in_flight;
  int          checked;
  int          wrap_count;
  logic [8:0]  vectors_seen;

  multi_channel_compare_timer u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  mcct_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .fail_count   (fail_count),
    .in_flight    (in_flight),
    .checked      (checked),
    .wrap_count   (wrap_count),
    .vectors_seen (vectors_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic item_t cmd_item(input cmd_t c, input logic [2:0] ch,
                                     input logic [15:0] v);
    return '{cmd: c, channel: ch, value: v};
  endfunction

  function automatic item_t rand_item(input int tick_pct);
    item_t it;
    int    r;
    r = $urandom_range(99);
    if (r < tick_pct) begin
      it.cmd = CMD_TICK;
    end else begin
      r = $urandom_range(99);
      it.cmd = (r < 30) ? CMD_SET_PERIOD : (r < 60) ? CMD_ENABLE : CMD_SERVICE;
    end
    it.channel = 3'($urandom_range(7));
    case ($urandom_range(9))
      0: it.value = 16'h0000;
      1: it.value = 16'hffff;
      2, 3, 4: it.value = 16'($urandom);
      default: it.value = 16'($urandom_range(200, 1));
    endcase
    return it;
  endfunction

  // Both tasks start and end at a rising edge.
  task automatic reg_write(input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DivideAddr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_done++;
  endtask

  task automatic send_item(input item_t it);
    if (!calm && $urandom_range(99) < StallPct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result side: random stalls, plus a long hold-off now and then so that
  // the block fills up and pushes back on the command side.
  initial begin
    int unsigned taken;
    int unsigned next_hold;
    int          hold;
    result_stall = 1'b0;
    taken        = 0;
    next_hold    = 300;
    hold         = 0;
    forever begin
      @(posedge clk);
      if (result_valid && !result_stall) taken++;
      if (hold == 0 && taken >= next_hold) begin
        hold      = HoldCycles;
        next_hold = next_hold + 19700;
      end
      if (hold > 0) begin
        result_stall <= 1'b1;
        hold--;
      end else begin
        result_stall <= !calm && ($urandom_range(99) < StallPct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WatchLimit) begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (result_valid && !result_stall) || rst || psel) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Timeout: no transfer for %0d cycles", WatchLimit);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    item_valid    = 1'b0;
    item          = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    calm          = 1'b0;
    settings_done = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    reg_write(32'd1);

    // Directed: empty service, periods of one, zero and all ones, the
    // ignored overflow period, flags that rise without enable, priority.
    send_item(cmd_item(CMD_SERVICE, 3'd0, 16'h0000));
    send_item(cmd_item(CMD_ENABLE, CH_OVERFLOW, 16'h0000));
    send_item(cmd_item(CMD_SET_PERIOD, 3'd0, 16'd3));
    send_item(cmd_item(CMD_SET_PERIOD, 3'd1, 16'h0000));
    send_item(cmd_item(CMD_SET_PERIOD, 3'd2, 16'd1));
    send_item(cmd_item(CMD_SET_PERIOD, 3'd6, 16'hffff));
    send_item(cmd_item(CMD_SET_PERIOD, CH_OVERFLOW, 16'd5));
    send_item(cmd_item(CMD_TICK, 3'd0, 16'h0000));
    send_item(cmd_item(CMD_TICK, 3'd7, 16'hffff));
    send_item(cmd_item(CMD_SERVICE, 3'd7, 16'hffff));
    send_item(cmd_item(CMD_ENABLE, 3'd2, 16'h0000));
    send_item(cmd_item(CMD_SET_PERIOD, 3'd3, 16'd4));
    send_item(cmd_item(CMD_SET_PERIOD, 3'd5, 16'd4));
    send_item(cmd_item(CMD_ENABLE, 3'd3, 16'h0000));
    send_item(cmd_item(CMD_ENABLE, 3'd5, 16'h0000));
    send_item(cmd_item(CMD_TICK, 3'd0, 16'h0000));
    send_item(cmd_item(CMD_ENABLE, 3'd0, 16'h0000));
    send_item(cmd_item(CMD_SERVICE, 3'd0, 16'h0000));
    send_item(cmd_item(CMD_SERVICE, 3'd0, 16'h0000));
    send_item(cmd_item(CMD_SET_PERIOD, 3'd0, 16'd5));
    send_item(cmd_item(CMD_ENABLE, 3'd0, 16'h0000));
    repeat (3) send_item(cmd_item(CMD_TICK, 3'd0, 16'h0000));
    send_item(cmd_item(CMD_SERVICE, 3'd0, 16'h0000));
    send_item(cmd_item(CMD_SERVICE, 3'd0, 16'h0000));

    for (int p = 0; p < 7; p++) begin
      wait_idle();
      case (p)
        0: reg_write(32'd1);
        1: reg_write(32'd0);
        2: reg_write(32'd2);
        3: reg_write(32'd64);
        4: reg_write(32'd127);
        5: reg_write(32'd65);
        default: reg_write(32'd3);
      endcase
      calm <= (p == 2);
      repeat (PhaseItems) send_item(rand_item(55));
    end

    // Mostly ticks at full rate; only the low seven bits of the write count.
    wait_idle();
    calm <= 1'b0;
    reg_write(32'hffff_ff81);
    repeat (TailItems) send_item(rand_item(97));
    wait_idle();

    $display("Checked %0d results across %0d divider settings; counter wrapped %0d times.",
             checked, settings_done, wrap_count);
    $display("Service vectors seen, one bit per vector code 8 down to 0: %b", vectors_seen);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/mcct_pkg.sv
rtl/core/mcct_prescaler.sv
rtl/core/mcct_channels.sv
rtl/core/multi_channel_compare_timer.sv
bench/mcct_checker.sv
bench/tb_multi_channel_compare_timer.sv
